// ===== src/spe_pkg.sv =====
// Shared types, codes and the sequencer microprogram of the sparse polynomial evaluator.
package spe_pkg;

  localparam int DEF_MAX_TERMS    = 32;
  localparam int DEF_MAX_EXPONENT = 31;

  localparam int TERMS_W = 6;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_EVAL   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_FULL = 2'd1;
  localparam logic [1:0] STS_SAT  = 2'd2;

  localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Q16_ONE   = 64'h0000_0000_0001_0000;
  localparam logic [95:0] RND_HALF  = 96'h8000;

  // sign-magnitude power of x with sticky clamp flag
  typedef struct packed {
    logic        ovf;
    logic        neg;
    logic [63:0] mag;
  } pow_t;

  typedef enum logic [3:0] {
    U_INIT = 4'd0,
    U_PLO  = 4'd1,
    U_PHI  = 4'd2,
    U_PFIN = 4'd3,
    U_TPW  = 4'd4,
    U_TLO  = 4'd5,
    U_THI  = 4'd6,
    U_TFIN = 4'd7,
    U_TSUM = 4'd8,
    U_DONE = 4'd9
  } step_t;

  typedef enum logic [1:0] {
    J_NONE = 2'd0,
    J_POW  = 2'd1,
    J_TERM = 2'd2
  } jmp_t;

  typedef struct packed {
    logic  init;
    logic  mul_en;
    logic  mul_hi;
    logic  term_src;
    logic  acc_ld;
    logic  rnd;
    logic  pfin;
    logic  tfin;
    logic  sum_en;
    logic  pow_rd_en;
    logic  done;
    jmp_t  jmp;
    step_t tgt;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    init: 1'b0, mul_en: 1'b0, mul_hi: 1'b0, term_src: 1'b0, acc_ld: 1'b0,
    rnd: 1'b0, pfin: 1'b0, tfin: 1'b0, sum_en: 1'b0, pow_rd_en: 1'b0,
    done: 1'b0, jmp: J_NONE, tgt: U_INIT
  };

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = CTRL_NOP;
    case (s)
      U_INIT: c.init = 1'b1;
      U_PLO: c.mul_en = 1'b1;
      U_PHI: begin
        c.mul_en = 1'b1;
        c.mul_hi = 1'b1;
        c.acc_ld = 1'b1;
        c.rnd    = 1'b1;
      end
      U_PFIN: begin
        c.pfin = 1'b1;
        c.jmp  = J_POW;
        c.tgt  = U_PLO;
      end
      U_TPW: begin
        c.sum_en    = 1'b1;
        c.pow_rd_en = 1'b1;
      end
      U_TLO: begin
        c.mul_en   = 1'b1;
        c.term_src = 1'b1;
      end
      U_THI: begin
        c.mul_en   = 1'b1;
        c.mul_hi   = 1'b1;
        c.term_src = 1'b1;
        c.acc_ld   = 1'b1;
      end
      U_TFIN: begin
        c.tfin = 1'b1;
        c.jmp  = J_TERM;
        c.tgt  = U_TPW;
      end
      U_TSUM: c.sum_en = 1'b1;
      U_DONE: c.done = 1'b1;
      default: c.done = 1'b1;
    endcase
    return c;
  endfunction

  // clamp a signed magnitude to the signed 64-bit range, zero is never negative
  function automatic pow_t clamp96(input logic neg, input logic [95:0] v);
    pow_t r;
    logic n;
    n = neg && (v != '0);
    r.neg = n;
    if (!n) begin
      if (v[95:63] != '0) begin
        r.ovf = 1'b1;
        r.mag = INT64_MAX;
      end else begin
        r.ovf = 1'b0;
        r.mag = v[63:0];
      end
    end else begin
      if ((v[95:64] != '0) || (v[63] && (v[62:0] != '0))) begin
        r.ovf = 1'b1;
        r.mag = INT64_MIN;
      end else begin
        r.ovf = 1'b0;
        r.mag = v[63:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== src/spe_in_if.sv =====
// Input item channel of the sparse polynomial evaluator.
interface spe_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] coefficient;
  logic [4:0]         exponent;
  logic signed [31:0] x_value;

  modport source (output valid, output action, output coefficient, output exponent,
                  output x_value, input ready);
  modport sink (input valid, input action, input coefficient, input exponent,
                input x_value, output ready);
endinterface

// ===== src/spe_out_if.sv =====
// Result item channel of the sparse polynomial evaluator.
interface spe_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [1:0]         status;
  logic [5:0]         terms_held;

  modport source (output valid, output value, output status, output terms_held,
                  input ready);
  modport sink (input valid, input value, input status, input terms_held,
                output ready);
endinterface

// ===== src/sparse_polynomial_evaluator_core.sv =====
// Sparse polynomial evaluator: term store, power table and microcoded evaluation sequencer.
//
//   channel   dir  beat moves                                   accept
//   in_ch     in   action, coefficient, exponent, x_value       valid && ready
//   out_ch    out  value, status, terms_held                    valid && ready
//
// Append, clear and unknown items are answered from idle without a run; an evaluate on an empty list too.
// In an evaluate, one shared 32x32 multiplier
// forms each 64x32 product in two passes, first over the power table, then per term.
// Reset (rst_n, synchronous) empties the list; the term and power memories keep contents.
// A result waits in the output register; a new beat is taken while it drains.
module sparse_polynomial_evaluator_core #(
  parameter int MAX_TERMS    = spe_pkg::DEF_MAX_TERMS,
  parameter int MAX_EXPONENT = spe_pkg::DEF_MAX_EXPONENT
) (
  input logic       clk,
  input logic       rst_n,
  spe_in_if.sink    in_ch,
  spe_out_if.source out_ch
);

  localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int KW = $clog2(MAX_EXPONENT + 1);
  localparam int PD = MAX_EXPONENT + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t          st_r, st_nxt;
  spe_pkg::step_t  upc_r, upc_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [KW-1:0]   k_r, k_nxt;

  logic            x_neg_r;
  logic [31:0]     xm_r;
  spe_pkg::pow_t   p_r;
  logic [63:0]     prod_r;
  logic [95:0]     acc_r;
  logic            t_neg_r;
  logic [63:0]     t_mag_r;
  logic [63:0]     sum_r;
  logic            ovf_r;

  logic [32:0]     tc_mem [MAX_TERMS];
  logic [KW-1:0]   te_mem [MAX_TERMS];
  spe_pkg::pow_t   pow_mem [PD];
  logic [32:0]     tc_rd_r;
  logic [KW-1:0]   te_rd_r;
  spe_pkg::pow_t   pow_rd_r;

  logic            out_valid_r, out_valid_nxt;
  logic [63:0]     out_value_r, out_value_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [5:0]      out_terms_r, out_terms_nxt;

  spe_pkg::ctrl_t  cw;
  logic            run;
  logic            in_fire;
  logic            out_free;
  logic            tbl_full;
  logic            more_pow;
  logic            more_term;
  logic            jump;
  logic            load_idle;
  logic            load_run;
  logic            do_append;

  logic [31:0]     cu;
  logic [31:0]     c_mag;
  logic [31:0]     xu;
  logic [KW-1:0]   e_sat;

  logic [63:0]     a_word;
  logic [31:0]     a32;
  logic [31:0]     b32;
  logic [63:0]     mul;
  logic [95:0]     full_prod;
  spe_pkg::pow_t   pcl;
  spe_pkg::pow_t   pnew;
  spe_pkg::pow_t   tcl;
  logic [64:0]     sum65;
  logic            sum_sat;
  logic [63:0]     sum_new;

  logic            pw_we;
  logic [KW-1:0]   pw_addr;
  spe_pkg::pow_t   pw_data;

  assign run       = (st_r == ST_RUN);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE) && out_free;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign tbl_full  = int'(cnt_r) >= MAX_TERMS;
  assign do_append = in_fire && (in_ch.action == spe_pkg::ACT_APPEND) && !tbl_full;

  always_comb begin
    cw = spe_pkg::ucode(upc_r);
    if (!run) begin
      cw = spe_pkg::CTRL_NOP;
    end
  end

  assign more_pow  = (int'(k_r) + 1) < MAX_EXPONENT;
  assign more_term = i_r < cnt_r;
  assign jump      = ((cw.jmp == spe_pkg::J_POW) && more_pow) ||
                     ((cw.jmp == spe_pkg::J_TERM) && more_term);

  assign cu    = in_ch.coefficient;
  assign c_mag = cu[31] ? (~cu + 32'd1) : cu;
  assign xu    = in_ch.x_value;
  assign e_sat = (int'(in_ch.exponent) > MAX_EXPONENT) ? KW'(MAX_EXPONENT)
                                                        : KW'(in_ch.exponent);

  assign a_word    = cw.term_src ? pow_rd_r.mag : p_r.mag;
  assign a32       = cw.mul_hi ? a_word[63:32] : a_word[31:0];
  assign b32       = cw.term_src ? tc_rd_r[31:0] : xm_r;
  assign mul       = a32 * b32;
  assign full_prod = acc_r + {prod_r, 32'b0};

  always_comb begin
    pcl      = spe_pkg::clamp96(p_r.neg ^ x_neg_r, {16'b0, full_prod[95:16]});
    pnew     = pcl;
    pnew.ovf = pcl.ovf | p_r.ovf;
    tcl      = spe_pkg::clamp96(pow_rd_r.neg ^ tc_rd_r[32], full_prod);
  end

  assign sum65   = t_neg_r ? ({sum_r[63], sum_r} - {1'b0, t_mag_r})
                           : ({sum_r[63], sum_r} + {1'b0, t_mag_r});
  assign sum_sat = (sum65[64] != sum65[63]);
  assign sum_new = sum_sat ? (sum65[64] ? spe_pkg::INT64_MIN : spe_pkg::INT64_MAX)
                           : sum65[63:0];

  assign load_idle = in_fire && !((in_ch.action == spe_pkg::ACT_EVAL) && (cnt_r != '0));
  assign load_run  = cw.done && out_free;

  always_comb begin
    st_nxt  = st_r;
    upc_nxt = upc_r;
    cnt_nxt = cnt_r;
    i_nxt   = i_r;
    k_nxt   = k_r;
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.action)
            spe_pkg::ACT_APPEND: begin
              if (!tbl_full) begin
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            spe_pkg::ACT_EVAL: begin
              if (cnt_r != '0) begin
                st_nxt  = ST_RUN;
                upc_nxt = spe_pkg::U_INIT;
                i_nxt   = '0;
              end
            end
            spe_pkg::ACT_CLEAR: cnt_nxt = '0;
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (cw.init) begin
          i_nxt = CW'(1);
          k_nxt = '0;
        end
        if (cw.pfin) begin
          k_nxt = k_r + KW'(1);
        end
        if (cw.tfin && more_term) begin
          i_nxt = i_r + CW'(1);
        end
        if (jump) begin
          upc_nxt = cw.tgt;
        end else if (cw.done) begin
          if (out_free) begin
            st_nxt = ST_IDLE;
          end
        end else begin
          upc_nxt = spe_pkg::step_t'(upc_r + 4'd1);
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_terms_nxt  = out_terms_r;
    if (load_idle) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = '0;
      out_status_nxt = ((in_ch.action == spe_pkg::ACT_APPEND) && tbl_full) ?
                       spe_pkg::STS_FULL : spe_pkg::STS_OK;
      out_terms_nxt  = spe_pkg::TERMS_W'(cnt_nxt);
    end else if (load_run) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = sum_r;
      out_status_nxt = ovf_r ? spe_pkg::STS_SAT : spe_pkg::STS_OK;
      out_terms_nxt  = spe_pkg::TERMS_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      upc_r       <= spe_pkg::U_INIT;
      cnt_r       <= '0;
      i_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      upc_r       <= upc_nxt;
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_terms_r  <= out_terms_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.action == spe_pkg::ACT_EVAL)) begin
      x_neg_r <= xu[31];
      xm_r    <= xu[31] ? (~xu + 32'd1) : xu;
    end
    if (cw.mul_en) begin
      prod_r <= mul;
    end
    if (cw.acc_ld) begin
      acc_r <= {32'b0, prod_r} + (cw.rnd ? spe_pkg::RND_HALF : 96'd0);
    end
    if (pw_we) begin
      p_r <= pw_data;
    end
    if (cw.init) begin
      t_neg_r <= 1'b0;
      t_mag_r <= '0;
      sum_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      ovf_r <= ovf_r | (cw.tfin && (tcl.ovf || pow_rd_r.ovf)) | (cw.sum_en && sum_sat);
      if (cw.tfin) begin
        t_neg_r <= tcl.neg;
        t_mag_r <= tcl.mag;
      end
      if (cw.sum_en) begin
        sum_r <= sum_new;
      end
    end
  end

  // term store
  always_ff @(posedge clk) begin
    if (do_append) begin
      tc_mem[cnt_r[IW-1:0]] <= {cu[31], c_mag};
      te_mem[cnt_r[IW-1:0]] <= e_sat;
    end
    if (cw.init || (cw.tfin && more_term)) begin
      tc_rd_r <= tc_mem[i_r[IW-1:0]];
      te_rd_r <= te_mem[i_r[IW-1:0]];
    end
  end

  // power table, entry k holds the rounded x^k of this evaluation
  assign pw_we   = cw.init || cw.pfin;
  assign pw_addr = cw.init ? '0 : (k_r + KW'(1));
  always_comb begin
    pw_data = pnew;
    if (cw.init) begin
      pw_data = '{ovf: 1'b0, neg: 1'b0, mag: spe_pkg::Q16_ONE};
    end
  end

  always_ff @(posedge clk) begin
    if (pw_we) begin
      pow_mem[pw_addr] <= pw_data;
    end
    if (cw.pow_rd_en) begin
      pow_rd_r <= pow_mem[te_rd_r];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = out_value_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.terms_held = out_terms_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= MAX_TERMS)
    else $error("term count above table depth");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.action == spe_pkg::ACT_APPEND) && tbl_full) |=> (cnt_r == $past(cnt_r)))
    else $error("append into a full table changed the count");

  a_pow_done: assert property (@(posedge clk) disable iff (!rst_n)
    (run && (upc_r == spe_pkg::U_TPW)) |-> (k_r == KW'(MAX_EXPONENT)))
    else $error("term pass entered before power table complete");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (run && (upc_r == spe_pkg::U_DONE) && !out_free) |=>
      (run && (upc_r == spe_pkg::U_DONE) && out_valid_r))
    else $error("evaluation result lost while output busy");

endmodule
